@@ rtl/core/heading_turn_pid_drive_defines.svh @@
// Assertion macros used by the checker file of the turn controller.
`ifndef HEADING_TURN_PID_DRIVE_DEFINES_SVH
`define HEADING_TURN_PID_DRIVE_DEFINES_SVH

// Condition and consequence in the same cycle.
`define HPID_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hpid check failed");

// Consequence in the cycle after the condition.
`define HPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hpid check failed");

`endif

@@ rtl/core/hpid_pkg.sv @@
package hpid_pkg;

    localparam int ANG_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int DRV_W    = 14;
    localparam int TOL_W    = 12;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;
    localparam int TGT_W    = ANG_W + 1;
    localparam int E_W      = ANG_W + 2;
    localparam int D_W      = E_W + 1;
    localparam int I_W      = 32;
    localparam int GAIN_SHIFT = 12;

    // Products of an unsigned gain (one sign bit added) and a signed operand.
    localparam int PP_W  = GAIN_W + 1 + E_W;
    localparam int PI_W  = GAIN_W + 1 + I_W;
    localparam int PD_W  = GAIN_W + 1 + D_W;
    localparam int ACC_W = PI_W + 2;
    localparam int U_W   = ACC_W - GAIN_SHIFT;

    localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [IDX_W-1:0] REG_DRIVE_MAX  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_MIN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_ANGLE_TOL  = 3'd5;
    localparam logic [IDX_W-1:0] REG_RATE_TOL   = 3'd6;
    localparam logic [IDX_W-1:0] REG_PERIOD_TOP = 3'd7;

    localparam logic       KIND_START  = 1'b0;
    localparam logic       KIND_SAMPLE = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_P_RST     = 16'd3840;
    localparam logic [GAIN_W-1:0] GAIN_I_RST     = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST     = 16'd1280;
    localparam logic [DRV_W-1:0]  DRIVE_MAX_RST  = 14'd8000;
    localparam logic [DRV_W-1:0]  DRIVE_MIN_RST  = 14'd4500;
    localparam logic [TOL_W-1:0]  ANGLE_TOL_RST  = 12'd16;
    localparam logic [TOL_W-1:0]  RATE_TOL_RST   = 12'd8;
    localparam logic [DRV_W-1:0]  PERIOD_TOP_RST = 14'd8400;

    localparam logic signed [I_W-1:0] I_MAX = {1'b0, {(I_W-1){1'b1}}};
    localparam logic signed [I_W-1:0] I_MIN = {1'b1, {(I_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [DRV_W-1:0]  drive_max;
        logic [DRV_W-1:0]  drive_min;
        logic [TOL_W-1:0]  angle_tol;
        logic [TOL_W-1:0]  rate_tol;
        logic [DRV_W-1:0]  period_top;
    } cfg_t;

    typedef struct packed {
        logic signed [E_W-1:0] err;
        logic signed [I_W-1:0] err_sum;
        logic signed [D_W-1:0] err_delta;
        logic                  stop;
        logic                  settled;
        logic                  busy;
    } step_t;

endpackage

@@ rtl/core/hpid_if.sv @@
interface hpid_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [hpid_pkg::ANG_W-1:0]   yaw;
    logic signed [hpid_pkg::ANG_W-1:0]   turn_angle;

    modport source (output valid, kind, yaw, turn_angle, input ready);
    modport sink   (input valid, kind, yaw, turn_angle, output ready);
endinterface

interface hpid_out_if;
    logic                          valid;
    logic                          ready;
    logic [hpid_pkg::DRV_W-1:0]    left_fwd_compare;
    logic [hpid_pkg::DRV_W-1:0]    left_rev_compare;
    logic [hpid_pkg::DRV_W-1:0]    right_fwd_compare;
    logic [hpid_pkg::DRV_W-1:0]    right_rev_compare;
    logic                          busy_res;
    logic                          settled;

    modport source (output valid, left_fwd_compare, left_rev_compare, right_fwd_compare,
                    right_rev_compare, busy_res, settled, input ready);
    modport sink   (input valid, left_fwd_compare, left_rev_compare, right_fwd_compare,
                    right_rev_compare, busy_res, settled, output ready);
endinterface

@@ rtl/core/heading_turn_pid_drive.sv @@
// In-place turn controller for a two-motor differential drive. A start request
// latches the target heading and runs the first step; each sample request then
// runs one PID step and yields one result holding the four motor compare values,
// the busy flag and the settled flag. One request is taken every clock cycle while
// the result side does not stall; its result passes the step, product and output
// registers before it is presented. That rate is set by the heading, integral
// and last-error registers, which are updated in the cycle a request is accepted,
// while the three gain multipliers and the output shaping run in two pipeline
// stages behind them. Configuration writes take effect at once and belong in idle
// periods; there is no clearing pass after reset.
module heading_turn_pid_drive (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hpid_pkg::IDX_W-1:0]    cfg_index,
    input  logic [hpid_pkg::CFG_W-1:0]    cfg_data,
    hpid_in_if.sink                       sample,
    hpid_out_if.source                    result
);
    import hpid_pkg::*;

    cfg_t                    cfg_reg;

    logic signed [TGT_W-1:0] target_reg, target_next;
    logic signed [I_W-1:0]   err_sum_reg, err_sum_next;
    logic signed [E_W-1:0]   prev_err_reg, prev_err_next;
    logic                    turning_reg, turning_next;

    logic                    step_valid_reg;
    step_t                   step_reg, step_next;
    logic                    law_ready, accept;

    logic signed [E_W-1:0]   yaw_x, err;
    logic signed [I_W:0]     sum_wide;
    logic signed [I_W-1:0]   sum_sat;
    logic signed [D_W-1:0]   delta;
    logic [E_W-1:0]          err_abs;
    logic [D_W-1:0]          delta_abs;
    logic                    is_start, near;

    assign sample.ready = !step_valid_reg || law_ready;
    assign accept       = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p     <= GAIN_P_RST;
            cfg_reg.gain_i     <= GAIN_I_RST;
            cfg_reg.gain_d     <= GAIN_D_RST;
            cfg_reg.drive_max  <= DRIVE_MAX_RST;
            cfg_reg.drive_min  <= DRIVE_MIN_RST;
            cfg_reg.angle_tol  <= ANGLE_TOL_RST;
            cfg_reg.rate_tol   <= RATE_TOL_RST;
            cfg_reg.period_top <= PERIOD_TOP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_P:     cfg_reg.gain_p     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     cfg_reg.gain_i     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     cfg_reg.gain_d     <= cfg_data[GAIN_W-1:0];
                REG_DRIVE_MAX:  cfg_reg.drive_max  <= cfg_data[DRV_W-1:0];
                REG_DRIVE_MIN:  cfg_reg.drive_min  <= cfg_data[DRV_W-1:0];
                REG_ANGLE_TOL:  cfg_reg.angle_tol  <= cfg_data[TOL_W-1:0];
                REG_RATE_TOL:   cfg_reg.rate_tol   <= cfg_data[TOL_W-1:0];
                REG_PERIOD_TOP: cfg_reg.period_top <= cfg_data[DRV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        is_start = (sample.kind == KIND_START);
        yaw_x    = E_W'(sample.yaw);

        // On a start the error is the turn angle itself and the history is cleared.
        if (is_start)
        begin
            target_next = TGT_W'(sample.yaw) + TGT_W'(sample.turn_angle);
            err         = E_W'(sample.turn_angle);
            sum_wide    = (I_W+1)'(err);
            delta       = D_W'(err);
        end
        else
        begin
            target_next = target_reg;
            err         = E_W'(target_reg) - yaw_x;
            sum_wide    = (I_W+1)'(err_sum_reg) + (I_W+1)'(err);
            delta       = D_W'(err) - D_W'(prev_err_reg);
        end

        if (sum_wide[I_W] != sum_wide[I_W-1])
            sum_sat = sum_wide[I_W] ? I_MIN : I_MAX;
        else
            sum_sat = sum_wide[I_W-1:0];

        err_abs   = err[E_W-1] ? E_W'(-err) : E_W'(err);
        delta_abs = delta[D_W-1] ? D_W'(-delta) : D_W'(delta);
        near      = (err_abs < E_W'(cfg_reg.angle_tol))
                 && (delta_abs < D_W'(cfg_reg.rate_tol));

        step_next.err       = err;
        step_next.err_sum   = sum_sat;
        step_next.err_delta = delta;

        err_sum_next  = err_sum_reg;
        prev_err_next = prev_err_reg;
        turning_next  = turning_reg;

        if (!is_start && !turning_reg)
        begin
            // A sample with no turn running only reports the stopped motors.
            target_next       = target_reg;
            step_next.stop    = 1'b1;
            step_next.settled = 1'b0;
            step_next.busy    = 1'b0;
        end
        else
        begin
            err_sum_next      = sum_sat;
            prev_err_next     = err;
            turning_next      = !near;
            step_next.stop    = near;
            step_next.settled = near;
            step_next.busy    = !near;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            err_sum_reg    <= '0;
            prev_err_reg   <= '0;
            turning_reg    <= 1'b0;
            step_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                target_reg   <= target_next;
                err_sum_reg  <= err_sum_next;
                prev_err_reg <= prev_err_next;
                turning_reg  <= turning_next;
            end
            if (sample.ready)
                step_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            step_reg <= step_next;
    end

    hpid_law u_law (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .step_valid (step_valid_reg),
        .step       (step_reg),
        .step_ready (law_ready),
        .result     (result)
    );

endmodule

@@ rtl/core/hpid_law.sv @@
module hpid_law (
    input  logic                clk,
    input  logic                rst_n,
    input  hpid_pkg::cfg_t      cfg,
    input  logic                step_valid,
    input  hpid_pkg::step_t     step,
    output logic                step_ready,
    hpid_out_if.source          result
);
    import hpid_pkg::*;

    // Product stage.
    logic                    mul_valid_reg;
    logic signed [PP_W-1:0]  prod_p_reg;
    logic signed [PI_W-1:0]  prod_i_reg;
    logic signed [PD_W-1:0]  prod_d_reg;
    logic                    mul_stop_reg;
    logic                    mul_settled_reg;
    logic                    mul_busy_reg;

    // Result stage.
    logic                    out_valid_reg;
    logic [DRV_W-1:0]        lf_reg, lr_reg, rf_reg, rr_reg;
    logic                    busy_reg, settled_reg;

    logic                    out_en, mul_en;
    logic signed [ACC_W-1:0] acc;
    logic signed [U_W-1:0]   u_val;
    logic [U_W-1:0]          u_abs;
    logic [DRV_W-1:0]        mag, pwm, pwm_floor;
    logic                    drive_pos;
    logic [DRV_W-1:0]        lf_next, lr_next, rf_next, rr_next;

    assign out_en     = !out_valid_reg || result.ready;
    assign mul_en     = !mul_valid_reg || out_en;
    assign step_ready = mul_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_en)
                mul_valid_reg <= step_valid;
            if (out_en)
                out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_p_reg      <= $signed({1'b0, cfg.gain_p}) * step.err;
            prod_i_reg      <= $signed({1'b0, cfg.gain_i}) * step.err_sum;
            prod_d_reg      <= $signed({1'b0, cfg.gain_d}) * step.err_delta;
            mul_stop_reg    <= step.stop;
            mul_settled_reg <= step.settled;
            mul_busy_reg    <= step.busy;
        end
    end

    always_comb
    begin
        acc = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);
        // Arithmetic shift gives the floor of the division by 4096.
        u_val = U_W'(acc >>> GAIN_SHIFT);
        u_abs = u_val[U_W-1] ? U_W'(-u_val) : U_W'(u_val);
        if (u_abs > U_W'(cfg.drive_max))
            mag = cfg.drive_max;
        else
            mag = u_abs[DRV_W-1:0];
        // A zero clamp turns a positive output into zero, which drives the other way.
        drive_pos = !u_val[U_W-1] && (u_val != '0) && (cfg.drive_max != '0);
        pwm_floor = (mag < cfg.drive_min) ? cfg.drive_min : mag;
        pwm       = (pwm_floor > cfg.period_top) ? cfg.period_top : pwm_floor;

        if (mul_stop_reg)
        begin
            lf_next = cfg.period_top;
            lr_next = cfg.period_top;
            rf_next = cfg.period_top;
            rr_next = cfg.period_top;
        end
        else if (drive_pos)
        begin
            lf_next = '0;
            lr_next = pwm;
            rf_next = pwm;
            rr_next = '0;
        end
        else
        begin
            lf_next = pwm;
            lr_next = '0;
            rf_next = '0;
            rr_next = pwm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            lf_reg      <= lf_next;
            lr_reg      <= lr_next;
            rf_reg      <= rf_next;
            rr_reg      <= rr_next;
            busy_reg    <= mul_busy_reg;
            settled_reg <= mul_settled_reg;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.left_fwd_compare  = lf_reg;
    assign result.left_rev_compare  = lr_reg;
    assign result.right_fwd_compare = rf_reg;
    assign result.right_rev_compare = rr_reg;
    assign result.busy_res          = busy_reg;
    assign result.settled           = settled_reg;

endmodule

@@ rtl/core/hpid_checker.sv @@
`include "heading_turn_pid_drive_defines.svh"

module hpid_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [hpid_pkg::DRV_W-1:0]   left_fwd,
    input  logic [hpid_pkg::DRV_W-1:0]   left_rev,
    input  logic [hpid_pkg::DRV_W-1:0]   right_fwd,
    input  logic [hpid_pkg::DRV_W-1:0]   right_rev,
    input  logic                         busy_res,
    input  logic                         settled
);

    // A stalled result keeps its payload.
    `HPID_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(left_fwd) && $stable(left_rev) && $stable(right_fwd) && $stable(right_rev) && $stable(busy_res) && $stable(settled))

    // The turn that settles is over.
    `HPID_ASSERT_NOW(a_settle_ends, clk, rst_n, out_valid && settled, !busy_res)

    // The left forward and reverse compares always equal the right reverse and forward ones.
    `HPID_ASSERT_NOW(a_mirror, clk, rst_n, out_valid, (left_fwd == right_rev) && (left_rev == right_fwd))

    // While turning, each motor is driven in one direction only.
    `HPID_ASSERT_NOW(a_one_dir, clk, rst_n, out_valid && busy_res, (left_fwd == 0) || (left_rev == 0))

endmodule

bind heading_turn_pid_drive hpid_checker u_hpid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .left_fwd  (result.left_fwd_compare),
    .left_rev  (result.left_rev_compare),
    .right_fwd (result.right_fwd_compare),
    .right_rev (result.right_rev_compare),
    .busy_res  (result.busy_res),
    .settled   (result.settled)
);

@@ test/tb_heading_turn_pid_drive.sv @@
module tb_heading_turn_pid_drive;
    timeunit 1ns;
    timeprecision 1ps;

    import hpid_pkg::*;

    typedef struct packed {
        logic [DRV_W-1:0] left_fwd;
        logic [DRV_W-1:0] left_rev;
        logic [DRV_W-1:0] right_fwd;
        logic [DRV_W-1:0] right_rev;
        logic             busy;
        logic             settled;
    } drive_cmd_t;

    typedef struct packed {
        logic                    kind;
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] turn;
        logic                    pinned;
        drive_cmd_t              want;
    } stim_row_t;

    typedef struct packed {
        logic       on;
        drive_cmd_t want;
    } fixed_answer_t;

    localparam drive_cmd_t STOP_CMD = '{PERIOD_TOP_RST, PERIOD_TOP_RST, PERIOD_TOP_RST,
                                        PERIOD_TOP_RST, 1'b0, 1'b0};
    localparam drive_cmd_t SETTLE_CMD = '{PERIOD_TOP_RST, PERIOD_TOP_RST, PERIOD_TOP_RST,
                                          PERIOD_TOP_RST, 1'b0, 1'b1};
    localparam drive_cmd_t NO_CMD = '0;

    // Rows with pinned answers assume the registers still hold their reset values.
    localparam stim_row_t DIRECTED_ROWS [22] = '{
        '{KIND_SAMPLE, 16'sd0,      16'sd0,      1'b1, STOP_CMD},
        '{KIND_SAMPLE, 16'sh8000,   16'sh7FFF,   1'b1, STOP_CMD},
        '{KIND_SAMPLE, 16'sh7FFF,   16'sh8000,   1'b1, STOP_CMD},
        '{KIND_START,  16'sd0,      16'sd0,      1'b1, SETTLE_CMD},
        '{KIND_START,  16'sd0,      16'sd1600,   1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sd400,    16'sd0,      1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sd1000,   16'sd0,      1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sd1500,   16'sd0,      1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sd1590,   16'sd0,      1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sd1598,   16'sd0,      1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sd1600,   16'sd0,      1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sd1600,   16'sd0,      1'b1, STOP_CMD},
        '{KIND_START,  16'sd100,    -16'sd800,   1'b0, NO_CMD},
        '{KIND_SAMPLE, -16'sd300,   16'sd0,      1'b0, NO_CMD},
        '{KIND_START,  -16'sd300,   16'sh7FFF,   1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sh8000,   16'sd0,      1'b0, NO_CMD},
        '{KIND_START,  16'sh7FFF,   16'sh7FFF,   1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sh8000,   16'sd0,      1'b0, NO_CMD},
        '{KIND_START,  16'sh8000,   16'sh8000,   1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sh7FFF,   16'sd0,      1'b0, NO_CMD},
        '{KIND_SAMPLE, 16'sh8000,   16'sd12345,  1'b0, NO_CMD},
        '{KIND_START,  16'sd5,      -16'sd5,     1'b1, SETTLE_CMD}
    };

    localparam cfg_t RESET_CFG = '{gain_p: GAIN_P_RST, gain_i: GAIN_I_RST, gain_d: GAIN_D_RST,
                                   drive_max: DRIVE_MAX_RST, drive_min: DRIVE_MIN_RST,
                                   angle_tol: ANGLE_TOL_RST, rate_tol: RATE_TOL_RST,
                                   period_top: PERIOD_TOP_RST};
    localparam cfg_t FULL_SCALE_CFG = '{gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF,
                                        drive_max: 14'h3FFF, drive_min: 14'h3FFF,
                                        angle_tol: 12'hFFF, rate_tol: 12'hFFF,
                                        period_top: 14'h3FFF};
    localparam cfg_t ZERO_CFG = '0;
    localparam cfg_t FLOOR_OVER_CLAMP_CFG = '{gain_p: GAIN_P_RST, gain_i: 16'd64,
                                              gain_d: GAIN_D_RST, drive_max: 14'd3000,
                                              drive_min: 14'd6000, angle_tol: ANGLE_TOL_RST,
                                              rate_tol: RATE_TOL_RST, period_top: 14'd5000};
    // Integral only and no settling, so the sum grows with every step.
    localparam cfg_t WINDUP_CFG = '{gain_p: 16'd0, gain_i: 16'd1, gain_d: 16'd0,
                                    drive_max: 14'h3FFF, drive_min: 14'd0, angle_tol: 12'd0,
                                    rate_tol: 12'd0, period_top: 14'h3FFF};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    hpid_in_if  sample_bus();
    hpid_out_if result_bus();

    heading_turn_pid_drive uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_bus),
        .result    (result_bus)
    );

    always #10 clk = ~clk;

    // Predictor state and the register copy it works from.
    cfg_t                    active_cfg = RESET_CFG;
    logic signed [TGT_W-1:0] tgt_heading = '0;
    logic signed [I_W-1:0]   err_sum = '0;
    logic signed [E_W-1:0]   last_err = '0;
    bit                      turning = 1'b0;

    drive_cmd_t    expected_cmds [$];
    fixed_answer_t fixed_answers [$];
    drive_cmd_t    accepted_cmd, seen_cmd, want_cmd;
    fixed_answer_t pin;

    int  mismatches = 0;
    int  requests_sent = 0;
    int  starts_seen = 0;
    int  results_checked = 0;
    int  settles_seen = 0;
    int  settings_loaded = 0;

    int  tx_left = 0, rx_left = 0;
    bit  tx_quiet = 1'b0, rx_quiet = 1'b0;
    bit  tx_forced = 1'b0, rx_forced = 1'b0;
    bit  hold_off_req = 1'b0;

    function automatic drive_cmd_t stop_cmd();
        drive_cmd_t cmd;
        cmd = '0;
        cmd.left_fwd  = active_cfg.period_top;
        cmd.left_rev  = active_cfg.period_top;
        cmd.right_fwd = active_cfg.period_top;
        cmd.right_rev = active_cfg.period_top;
        return cmd;
    endfunction

    function automatic drive_cmd_t turn_step(input logic kind,
                                             input logic signed [ANG_W-1:0] yaw,
                                             input logic signed [ANG_W-1:0] turn);
        longint err, delta, total, acc, u, mag, lim;
        drive_cmd_t cmd;
        cmd = '0;
        if (kind == KIND_START) begin
            tgt_heading = yaw + turn;
            err_sum = '0;
            last_err = '0;
            turning = 1'b1;
        end else if (!turning) begin
            return stop_cmd();
        end

        err = longint'(tgt_heading) - longint'(yaw);
        total = longint'(err_sum) + err;
        if (total > longint'(I_MAX)) total = longint'(I_MAX);
        if (total < longint'(I_MIN)) total = longint'(I_MIN);
        err_sum = I_W'(total);
        delta = err - longint'(last_err);
        last_err = E_W'(err);

        acc = longint'(active_cfg.gain_p) * err + longint'(active_cfg.gain_i) * longint'(err_sum)
              + longint'(active_cfg.gain_d) * delta;
        u = acc >>> GAIN_SHIFT;
        lim = longint'(active_cfg.drive_max);
        if (u > lim) u = lim;
        if (u < -lim) u = -lim;

        // The floor is applied after the clamp, and the compare ceiling caps both.
        mag = (u < 0) ? -u : u;
        if (mag < longint'(active_cfg.drive_min)) mag = longint'(active_cfg.drive_min);
        if (mag > longint'(active_cfg.period_top)) mag = longint'(active_cfg.period_top);

        // A zero output takes the same direction as a negative one.
        if (u > 0) begin
            cmd.left_rev  = DRV_W'(mag);
            cmd.right_fwd = DRV_W'(mag);
        end else begin
            cmd.left_fwd  = DRV_W'(mag);
            cmd.right_rev = DRV_W'(mag);
        end

        if (((err < 0) ? -err : err) < longint'(active_cfg.angle_tol) &&
            ((delta < 0) ? -delta : delta) < longint'(active_cfg.rate_tol)) begin
            cmd = stop_cmd();
            turning = 1'b0;
            cmd.settled = 1'b1;
        end
        cmd.busy = turning;
        return cmd;
    endfunction

    // Waits per item, with stretches where one side never idles.
    function automatic int draw_wait(inout int left, inout bit quiet, input bit forced);
        if (left == 0) begin
            left = $urandom_range(8, 40);
            quiet = ($urandom_range(0, 3) == 0);
        end
        left--;
        if (forced || quiet) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic int unsigned pick(input int unsigned top_val, input int unsigned rst_val,
                                         input int unsigned usual);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return top_val;
            2: return rst_val;
            3: return $urandom_range(0, top_val);
            default: return $urandom_range(0, usual);
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.gain_p     = GAIN_W'(pick(16'hFFFF, GAIN_P_RST, 8192));
        s.gain_i     = GAIN_W'(pick(16'hFFFF, GAIN_I_RST, 256));
        s.gain_d     = GAIN_W'(pick(16'hFFFF, GAIN_D_RST, 4096));
        s.drive_max  = DRV_W'(pick(14'h3FFF, DRIVE_MAX_RST, 14'h3FFF));
        s.drive_min  = DRV_W'(pick(14'h3FFF, DRIVE_MIN_RST, 8000));
        s.angle_tol  = TOL_W'(pick(12'hFFF, ANGLE_TOL_RST, 64));
        s.rate_tol   = TOL_W'(pick(12'hFFF, RATE_TOL_RST, 64));
        s.period_top = DRV_W'(pick(14'h3FFF, PERIOD_TOP_RST, 14'h3FFF));
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_request(input logic kind, input logic signed [ANG_W-1:0] yaw,
                                input logic signed [ANG_W-1:0] turn, input logic pinned,
                                input drive_cmd_t want);
        int gap;
        gap = draw_wait(tx_left, tx_quiet, tx_forced);
        if (gap > 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fixed_answers.push_back(fixed_answer_t'{pinned, want});
        sample_bus.valid      <= 1'b1;
        sample_bus.kind       <= kind;
        sample_bus.yaw        <= yaw;
        sample_bus.turn_angle <= turn;
        do @(posedge clk); while (sample_bus.ready !== 1'b1);
        requests_sent++;
    endtask

    // Every request yields a result, so an empty queue means the block is idle.
    task automatic drain();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_cmds.size() != 0) @(posedge clk);
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        drain();
        put_reg(REG_GAIN_P,     CFG_W'(s.gain_p));
        put_reg(REG_GAIN_I,     CFG_W'(s.gain_i));
        put_reg(REG_GAIN_D,     CFG_W'(s.gain_d));
        put_reg(REG_DRIVE_MAX,  CFG_W'(s.drive_max));
        put_reg(REG_DRIVE_MIN,  CFG_W'(s.drive_min));
        put_reg(REG_ANGLE_TOL,  CFG_W'(s.angle_tol));
        put_reg(REG_RATE_TOL,   CFG_W'(s.rate_tol));
        put_reg(REG_PERIOD_TOP, CFG_W'(s.period_top));
        cfg_write <= 1'b0;
        active_cfg = s;
        settings_loaded++;
    endtask

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1) begin
                accepted_cmd = turn_step(sample_bus.kind, sample_bus.yaw, sample_bus.turn_angle);
                if (fixed_answers.size() != 0) begin
                    pin = fixed_answers.pop_front();
                    if (pin.on) accepted_cmd = pin.want;
                end
                if (sample_bus.kind == KIND_START) starts_seen++;
                expected_cmds.push_back(accepted_cmd);
            end
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
                seen_cmd.left_fwd  = result_bus.left_fwd_compare;
                seen_cmd.left_rev  = result_bus.left_rev_compare;
                seen_cmd.right_fwd = result_bus.right_fwd_compare;
                seen_cmd.right_rev = result_bus.right_rev_compare;
                seen_cmd.busy      = result_bus.busy_res;
                seen_cmd.settled   = result_bus.settled;
                if (expected_cmds.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want_cmd = expected_cmds.pop_front();
                    results_checked++;
                    if (want_cmd.settled) settles_seen++;
                    if (seen_cmd !== want_cmd)
                        report_mismatch($sformatf(
                            "got %0d/%0d/%0d/%0d busy %b settled %b, want %0d/%0d/%0d/%0d busy %b settled %b",
                            seen_cmd.left_fwd, seen_cmd.left_rev, seen_cmd.right_fwd,
                            seen_cmd.right_rev, seen_cmd.busy, seen_cmd.settled,
                            want_cmd.left_fwd, want_cmd.left_rev, want_cmd.right_fwd,
                            want_cmd.right_rev, want_cmd.busy, want_cmd.settled));
                end
            end
        end
    end

    // Result side: random stalls, and one long hold-off while requests keep coming.
    initial
    begin
        int stall;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = 150;
            end else begin
                stall = draw_wait(rx_left, rx_quiet, rx_forced);
            end
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (result_bus.valid !== 1'b1);
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_heading_turn_pid_drive NOT OK");
        $finish;
    end

    initial
    begin
        stim_row_t               row;
        cfg_t                    setting;
        logic signed [ANG_W-1:0] start_yaw, turn_req, jolt;
        longint                  aim, heading;
        int                      phase_items, steps;

        rst_n                 <= 1'b0;
        cfg_write             <= 1'b0;
        cfg_index             <= REG_GAIN_P;
        cfg_data              <= '0;
        sample_bus.valid      <= 1'b0;
        sample_bus.kind       <= KIND_SAMPLE;
        sample_bus.yaw        <= '0;
        sample_bus.turn_angle <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            row = DIRECTED_ROWS[i];
            send_request(row.kind, row.yaw, row.turn, row.pinned, row.want);
        end

        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: setting = FULL_SCALE_CFG;
                1: setting = ZERO_CFG;
                2: setting = FLOOR_OVER_CLAMP_CFG;
                default: setting = random_settings();
            endcase
            load_settings(setting);
            if (phase == 4) hold_off_req = 1'b1;
            phase_items = 0;
            while (phase_items < 82) begin
                tx_forced = (phase == 4 && phase_items < 40);
                if ($urandom_range(0, 9) == 0) begin
                    send_request(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                                 1'b0, NO_CMD);
                    phase_items++;
                end else begin
                    // A turn: start, then headings closing in on the target,
                    // with an occasional wild reading.
                    start_yaw = 16'($urandom);
                    if ($urandom_range(0, 3) == 0) turn_req = 16'($urandom);
                    else turn_req = 16'($urandom_range(0, 8000) - 4000);
                    send_request(KIND_START, start_yaw, turn_req, 1'b0, NO_CMD);
                    aim = longint'(start_yaw) + longint'(turn_req);
                    heading = start_yaw;
                    steps = $urandom_range(2, 24);
                    phase_items += steps + 1;
                    repeat (steps) begin
                        if ($urandom_range(0, 9) == 0) begin
                            jolt = 16'($urandom);
                            heading = jolt;
                        end else begin
                            heading = heading + (aim - heading) * longint'($urandom_range(30, 100))
                                      / 100 + longint'($urandom_range(0, 4)) - 2;
                        end
                        if (heading > 32767) heading = 32767;
                        if (heading < -32768) heading = -32768;
                        send_request(KIND_SAMPLE, ANG_W'(heading), 16'($urandom), 1'b0, NO_CMD);
                    end
                end
            end
            tx_forced = 1'b0;
        end

        // Integral only: the largest errors of each sign, back to back.
        load_settings(WINDUP_CFG);
        tx_forced = 1'b1;
        rx_forced = 1'b1;
        send_request(KIND_START, 16'sh7FFF, 16'sh7FFF, 1'b0, NO_CMD);
        repeat (12)
            send_request(KIND_SAMPLE, 16'h8000 | 16'($urandom_range(0, 255)), 16'($urandom),
                         1'b0, NO_CMD);
        send_request(KIND_START, 16'sh8000, 16'sh8000, 1'b0, NO_CMD);
        repeat (12)
            send_request(KIND_SAMPLE, 16'h7FFF - 16'($urandom_range(0, 255)), 16'($urandom),
                         1'b0, NO_CMD);
        tx_forced = 1'b0;
        rx_forced = 1'b0;

        drain();
        repeat (10) @(posedge clk);

        $display("Run covered %0d requests with %0d turn starts under %0d register settings.",
                 requests_sent, starts_seen, settings_loaded + 1);
        $display("Checked %0d results, %0d settled turns, integral-only runs at both error extremes, %0d mismatches.",
                 results_checked, settles_seen, mismatches);
        if (mismatches == 0)
            $display("tb_heading_turn_pid_drive OK");
        else
            $display("tb_heading_turn_pid_drive NOT OK");
        $finish;
    end

endmodule
